// ===== rtl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared constants and helpers for the line prefix replacer
// Holds the line modes, register indexes, field widths and byte selection.
// ----------------------------------------------------------------------------
package lpr_pkg;

	// field and register widths
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 64;
	localparam int PLEN_W      = 4;
	localparam int RLEN_W      = 5;
	localparam int REG_IDX_W   = 3;
	localparam int PREFIX_MAX  = 8;
	localparam int REPLACE_MAX = 16;

	// line modes
	localparam logic [1:0] MODE_MATCH = 2'd0;
	localparam logic [1:0] MODE_PASS  = 2'd1;
	localparam logic [1:0] MODE_DROP  = 2'd2;

	// register indexes on the write port
	localparam logic [REG_IDX_W-1:0] REG_PREFIX_BYTES  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PREFIX_LEN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REPL_LOW      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REPL_HIGH     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REPL_LEN      = 3'd4;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	// pick byte idx out of a 64-bit word, byte 0 least significant
	function automatic logic [BYTE_W-1:0] byte_of(input logic [WORD_W-1:0] w,
		input logic [2:0] idx);
		logic [BYTE_W-1:0] b;
		b = w[idx*BYTE_W +: BYTE_W];
		return b;
	endfunction

endpackage

// ===== rtl/line_prefix_replacer.sv =====
// ----------------------------------------------------------------------------
// line_prefix_replacer: rewrites lines that begin with a configured prefix
// Matches line starts against the prefix, emits the replacement on a full
// match and replays partial matches; bytes leave at most one per cycle.
// ----------------------------------------------------------------------------
// After a full match the rest of the line is dropped but for its newline;
// other lines pass unchanged. An accepted input byte loads the sequencer
// job, which moves its results (0 to 16) into the output register while it
// is free; in_stall stays high until the last one is sent, so no new byte
// is taken during a job. Reset (arst_n low, asynchronous) sets matching at
// line start, lengths 1, prefix and replacement bytes 0, and empties output.
module line_prefix_replacer (
	input  logic                              clk,
	input  logic                              arst_n,
	// register write port
	input  logic                              wr_en,
	input  logic [lpr_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [lpr_pkg::WORD_W-1:0]        wr_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lpr_pkg::BYTE_W-1:0]        in_byte,
	input  logic                              end_of_input,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lpr_pkg::BYTE_W-1:0]        out_byte,
	output logic                              last_of_run
);

	// configuration registers
	logic [lpr_pkg::WORD_W-1:0] prefix_bytes_q;
	logic [lpr_pkg::PLEN_W-1:0] prefix_length_q;
	logic [lpr_pkg::WORD_W-1:0] repl_low_q;
	logic [lpr_pkg::WORD_W-1:0] repl_high_q;
	logic [lpr_pkg::RLEN_W-1:0] repl_length_q;

	// line state
	logic [1:0]                 mode_q;
	logic [lpr_pkg::PLEN_W-1:0] matched_q;

	// sequencer job
	logic                       busy_q;
	logic                       src_repl_q;
	logic [3:0]                 idx_q;
	logic [lpr_pkg::RLEN_W-1:0] remain_q;
	logic                       tail_q;
	logic [lpr_pkg::BYTE_W-1:0] tail_byte_q;

	// output register
	logic                       out_valid_q;
	logic [lpr_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_last_q;

	logic [lpr_pkg::PLEN_W-1:0] plen;
	logic [lpr_pkg::RLEN_W-1:0] rlen;
	logic [lpr_pkg::PLEN_W-1:0] m_cur;
	logic [lpr_pkg::PLEN_W-1:0] m_inc;
	logic [1:0]                 mode_cur;
	logic                       in_acc;
	logic                       emit;
	logic                       is_nl;
	logic                       pfx_hit;

	logic [1:0]                 mode_nxt;
	logic [lpr_pkg::PLEN_W-1:0] matched_nxt;
	logic [lpr_pkg::RLEN_W-1:0] job_count;
	logic                       job_repl;
	logic                       job_tail;

	logic [lpr_pkg::BYTE_W-1:0] src_byte;
	logic                       src_last;
	logic                       job_done;

	// clamp the lengths into range
	always_comb begin
		if (prefix_length_q == '0)
			plen = lpr_pkg::PLEN_W'(1);
		else if (prefix_length_q > lpr_pkg::PLEN_W'(lpr_pkg::PREFIX_MAX))
			plen = lpr_pkg::PLEN_W'(lpr_pkg::PREFIX_MAX);
		else
			plen = prefix_length_q;
		if (repl_length_q == '0)
			rlen = lpr_pkg::RLEN_W'(1);
		else if (repl_length_q > lpr_pkg::RLEN_W'(lpr_pkg::REPLACE_MAX))
			rlen = lpr_pkg::RLEN_W'(lpr_pkg::REPLACE_MAX);
		else
			rlen = repl_length_q;
	end

	// normalised line state for this byte
	assign m_cur    = (matched_q >= plen) ? '0 : matched_q;
	assign m_inc    = m_cur + lpr_pkg::PLEN_W'(1);
	assign mode_cur = (mode_q == lpr_pkg::MODE_PASS || mode_q == lpr_pkg::MODE_DROP) ?
		mode_q : lpr_pkg::MODE_MATCH;
	assign is_nl    = (in_byte == lpr_pkg::NEWLINE);
	assign pfx_hit  = (in_byte == lpr_pkg::byte_of(prefix_bytes_q, m_cur[2:0]));

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;

	// decide next line state and the burst this byte causes
	always_comb begin
		mode_nxt    = mode_cur;
		matched_nxt = m_cur;
		job_count   = '0;
		job_repl    = 1'b0;
		job_tail    = 1'b0;
		if (end_of_input) begin
			if (mode_cur == lpr_pkg::MODE_MATCH)
				job_count = lpr_pkg::RLEN_W'(m_cur);
			mode_nxt    = lpr_pkg::MODE_MATCH;
			matched_nxt = '0;
		end else begin
			unique case (mode_cur)
				lpr_pkg::MODE_PASS: begin
					job_tail = 1'b1;
					if (is_nl)
						mode_nxt = lpr_pkg::MODE_MATCH;
				end
				lpr_pkg::MODE_DROP: begin
					if (is_nl) begin
						job_tail = 1'b1;
						mode_nxt = lpr_pkg::MODE_MATCH;
					end
				end
				default: begin
					if (pfx_hit) begin
						if (m_inc >= plen) begin
							job_count   = rlen;
							job_repl    = 1'b1;
							mode_nxt    = lpr_pkg::MODE_DROP;
							matched_nxt = '0;
						end else begin
							matched_nxt = m_inc;
						end
					end else begin
						job_count   = lpr_pkg::RLEN_W'(m_cur);
						job_tail    = 1'b1;
						matched_nxt = '0;
						mode_nxt    = is_nl ? lpr_pkg::MODE_MATCH : lpr_pkg::MODE_PASS;
					end
				end
			endcase
		end
	end

	// shared byte selector over prefix or replacement
	always_comb begin
		if (src_repl_q)
			src_byte = lpr_pkg::byte_of(idx_q[3] ? repl_high_q : repl_low_q, idx_q[2:0]);
		else
			src_byte = lpr_pkg::byte_of(prefix_bytes_q, idx_q[2:0]);
		src_last = (remain_q == lpr_pkg::RLEN_W'(1)) && !tail_q;
		job_done = src_last || (remain_q == '0);
	end

	assign emit = busy_q && (!out_valid_q || !out_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_bytes_q  <= '0;
			prefix_length_q <= lpr_pkg::PLEN_W'(1);
			repl_low_q      <= '0;
			repl_high_q     <= '0;
			repl_length_q   <= lpr_pkg::RLEN_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				lpr_pkg::REG_PREFIX_BYTES: prefix_bytes_q  <= wr_data;
				lpr_pkg::REG_PREFIX_LEN:   prefix_length_q <= wr_data[lpr_pkg::PLEN_W-1:0];
				lpr_pkg::REG_REPL_LOW:     repl_low_q      <= wr_data;
				lpr_pkg::REG_REPL_HIGH:    repl_high_q     <= wr_data;
				lpr_pkg::REG_REPL_LEN:     repl_length_q   <= wr_data[lpr_pkg::RLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// line state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= lpr_pkg::MODE_MATCH;
			matched_q   <= '0;
			busy_q      <= 1'b0;
			src_repl_q  <= 1'b0;
			idx_q       <= '0;
			remain_q    <= '0;
			tail_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				mode_q     <= mode_nxt;
				matched_q  <= matched_nxt;
				busy_q     <= (job_count != '0) || job_tail;
				src_repl_q <= job_repl;
				idx_q      <= '0;
				remain_q   <= job_count;
				tail_q     <= job_tail;
			end else if (emit) begin
				if (remain_q != '0) begin
					remain_q <= remain_q - lpr_pkg::RLEN_W'(1);
					idx_q    <= idx_q + 4'd1;
				end else begin
					tail_q <= 1'b0;
				end
				if (job_done)
					busy_q <= 1'b0;
			end
			// output register
			if (emit) begin
				out_valid_q <= 1'b1;
				out_last_q  <= job_done;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc)
			tail_byte_q <= in_byte;
		if (emit)
			out_byte_q <= (remain_q != '0) ? src_byte : tail_byte_q;
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = out_last_q;

	// checks
	a_matched_range: assert property (@(posedge clk) disable iff (!arst_n)
		matched_q < lpr_pkg::PLEN_W'(lpr_pkg::PREFIX_MAX))
		else $error("matched count out of range");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("unused line mode reached");

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (remain_q != '0) || tail_q)
		else $error("sequencer busy with nothing to send");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		emit && job_done |=> !busy_q && out_valid_q && out_last_q)
		else $error("final word did not end the burst");

endmodule
